// ===== design/wvrt_pkg.sv =====
`default_nettype none
package wvrt_pkg;

    localparam int VALUE_W_DEF = 32;
    localparam int TIME_W_DEF  = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FWD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_PRESENT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_PRESENT = 3'd5;

    localparam logic [1:0] POL_SKIP   = 2'd0;
    localparam logic [1:0] POL_ZERO   = 2'd1;
    localparam logic [1:0] POL_REJECT = 2'd2;
    localparam logic [1:0] POL_BREAK  = 2'd3;

    localparam logic [1:0] ST_READY  = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;

    localparam logic [1:0] CHK_OK   = 2'd0;
    localparam logic [1:0] CHK_SKIP = 2'd1;
    localparam logic [1:0] CHK_FAIL = 2'd2;

    typedef struct packed {
        logic signed [CFG_DATA_W-1:0] win_min;
        logic signed [CFG_DATA_W-1:0] win_max;
        logic [1:0]                   policy;
        logic                         hold_fwd;
        logic                         value_present;
        logic                         range_present;
    } t_cfg;

    typedef struct packed {
        logic       in_win;
        logic       pre_win;
        logic [1:0] chk;
    } t_class;

endpackage
`default_nettype wire

// ===== design/wvrt_classify.sv =====
`default_nettype none
module wvrt_classify
    import wvrt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF,
    parameter int TIME_WIDTH  = TIME_W_DEF
) (
    input  t_cfg                          i_cfg,
    input  logic signed [TIME_WIDTH-1:0]  i_timestamp,
    input  logic signed [VALUE_WIDTH-1:0] i_sample_value,
    input  logic                          i_value_finite,
    input  logic signed [VALUE_WIDTH-1:0] i_range_low,
    input  logic                          i_low_finite,
    input  logic signed [VALUE_WIDTH-1:0] i_range_high,
    input  logic                          i_high_finite,
    output t_class                        o_class,
    output logic signed [VALUE_WIDTH-1:0] o_lo,
    output logic signed [VALUE_WIDTH-1:0] o_hi
);

    function automatic logic [1:0] fix_chk(input logic finite, input logic [1:0] policy);
        logic [1:0] res;
        res = CHK_OK;
        if (!finite) begin
            case (policy)
                POL_ZERO:   res = CHK_OK;
                POL_REJECT: res = CHK_FAIL;
                default:    res = CHK_SKIP;
            endcase
        end
        return res;
    endfunction

    logic signed [CFG_DATA_W-1:0]  ts_ext;
    logic signed [VALUE_WIDTH-1:0] y_fix, l_fix, h_fix, l_sel, h_sel;
    logic                          y_fin;
    logic [1:0]                    chk_y, chk_l, chk_h;

    always_comb begin
        ts_ext = CFG_DATA_W'(i_timestamp);
        o_class.in_win = (i_cfg.win_min <= i_cfg.win_max) &&
                         (ts_ext >= i_cfg.win_min) && (ts_ext <= i_cfg.win_max);
        o_class.pre_win = ts_ext < i_cfg.win_min;

        y_fin = i_cfg.value_present ? i_value_finite : 1'b1;
        y_fix = (i_cfg.value_present && i_value_finite) ? i_sample_value : '0;
        l_fix = i_low_finite ? i_range_low : '0;
        h_fix = i_high_finite ? i_range_high : '0;
        chk_y = fix_chk(y_fin, i_cfg.policy);
        chk_l = fix_chk(i_low_finite, i_cfg.policy);
        chk_h = fix_chk(i_high_finite, i_cfg.policy);

        if (chk_y != CHK_OK) begin
            o_class.chk = chk_y;
        end else if (i_cfg.range_present) begin
            o_class.chk = (chk_l != CHK_OK) ? chk_l : chk_h;
        end else begin
            o_class.chk = CHK_OK;
        end

        l_sel = i_cfg.range_present ? l_fix : y_fix;
        h_sel = i_cfg.range_present ? h_fix : y_fix;
        // swapped bounds
        if (h_sel < l_sel) begin
            o_lo = h_sel;
            o_hi = l_sel;
        end else begin
            o_lo = l_sel;
            o_hi = h_sel;
        end
    end

endmodule
`default_nettype wire

// ===== design/wvrt_scan.sv =====
`default_nettype none
module wvrt_scan
    import wvrt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF,
    parameter int TIME_WIDTH  = TIME_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_step,
    input  logic                          i_last,
    input  t_class                        i_class,
    input  logic signed [TIME_WIDTH-1:0]  i_timestamp,
    input  logic signed [VALUE_WIDTH-1:0] i_lo,
    input  logic signed [VALUE_WIDTH-1:0] i_hi,
    output logic [1:0]                    o_status,
    output logic signed [VALUE_WIDTH-1:0] o_range_min,
    output logic signed [VALUE_WIDTH-1:0] o_range_max
);

    logic signed [VALUE_WIDTH-1:0] r_run_min, r_run_max, n_run_min, n_run_max;
    logic signed [VALUE_WIDTH-1:0] r_held_min, r_held_max, n_held_min, n_held_max;
    logic signed [TIME_WIDTH-1:0]  r_held_time, n_held_time;
    logic r_run_valid, n_run_valid, r_failed, n_failed;
    logic r_held_cand, n_held_cand, r_held_valued, n_held_valued;
    logic r_held_broken, n_held_broken;
    logic upd;
    logic signed [VALUE_WIDTH-1:0] fin_min, fin_max;
    logic fin_valid;

    always_comb begin
        n_run_min     = r_run_min;
        n_run_max     = r_run_max;
        n_run_valid   = r_run_valid;
        n_failed      = r_failed;
        n_held_cand   = r_held_cand;
        n_held_valued = r_held_valued;
        n_held_broken = r_held_broken;
        n_held_time   = r_held_time;
        n_held_min    = r_held_min;
        n_held_max    = r_held_max;

        upd = !r_failed && (i_class.in_win || (i_cfg.hold_fwd && i_class.pre_win));
        if (!i_class.in_win && r_held_cand && (i_timestamp <= r_held_time)) begin
            upd = 1'b0;
        end

        if (upd) begin
            if (i_class.in_win) begin
                if (i_class.chk == CHK_FAIL) begin
                    n_failed = 1'b1;
                end else if (i_class.chk == CHK_OK) begin
                    n_run_valid = 1'b1;
                    if (!r_run_valid || (i_lo < r_run_min)) n_run_min = i_lo;
                    if (!r_run_valid || (i_hi > r_run_max)) n_run_max = i_hi;
                end
            end else if (i_class.chk == CHK_OK) begin
                n_held_cand   = 1'b1;
                n_held_valued = 1'b1;
                n_held_broken = 1'b0;
                n_held_time   = i_timestamp;
                n_held_min    = i_lo;
                n_held_max    = i_hi;
            end else if (i_cfg.policy == POL_BREAK) begin
                n_held_cand   = 1'b1;
                n_held_valued = 1'b0;
                n_held_broken = 1'b1;
                n_held_time   = i_timestamp;
            end else if (i_class.chk == CHK_FAIL) begin
                n_held_cand   = 1'b1;
                n_held_valued = 1'b0;
                n_held_broken = 1'b0;
                n_held_time   = i_timestamp;
            end
        end

        // merge held pre-window range
        fin_min   = n_run_min;
        fin_max   = n_run_max;
        fin_valid = n_run_valid;
        if (n_held_cand && n_held_valued) begin
            fin_valid = 1'b1;
            if (!n_run_valid || (n_held_min < n_run_min)) fin_min = n_held_min;
            if (!n_run_valid || (n_held_max > n_run_max)) fin_max = n_held_max;
        end

        o_range_min = '0;
        o_range_max = '0;
        if (i_cfg.win_min > i_cfg.win_max) begin
            o_status = ST_EMPTY;
        end else if (n_failed || (n_held_cand && !n_held_valued && !n_held_broken)) begin
            o_status = ST_FAILED;
        end else if (fin_valid) begin
            o_status    = ST_READY;
            o_range_min = fin_min;
            o_range_max = fin_max;
        end else begin
            o_status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid   <= 1'b0;
            r_failed      <= 1'b0;
            r_held_cand   <= 1'b0;
            r_held_valued <= 1'b0;
            r_held_broken <= 1'b0;
        end else if (i_step) begin
            r_run_valid   <= n_run_valid && !i_last;
            r_failed      <= n_failed && !i_last;
            r_held_cand   <= n_held_cand && !i_last;
            r_held_valued <= n_held_valued && !i_last;
            r_held_broken <= n_held_broken && !i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_run_min   <= n_run_min;
            r_run_max   <= n_run_max;
            r_held_time <= n_held_time;
            r_held_min  <= n_held_min;
            r_held_max  <= n_held_max;
        end
    end

endmodule
`default_nettype wire

// ===== design/windowed_value_range_tracker.sv =====
`default_nettype none
// windowed value range tracker: accepts one sample per clock and keeps the running min/max of
// samples whose timestamp lies in the configured window, with optional hold-forward of the
// latest pre-window sample; the sample flagged last produces one result (ready, empty or
// failed) in the output register and clears the scan state. a sample goes through an input
// register and one pass of compare logic into the result register, so the sustained rate is
// one sample per cycle; the output register lets the next sample in while a result waits, only
// a further last sample waits until the output is taken. configuration is written through its
// own port; the user must do so only while the block is idle, the block does not enforce it.
module windowed_value_range_tracker
    import wvrt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF,
    parameter int TIME_WIDTH  = TIME_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [TIME_WIDTH-1:0]  i_timestamp,
    input  logic signed [VALUE_WIDTH-1:0] i_sample_value,
    input  logic                          i_value_finite,
    input  logic signed [VALUE_WIDTH-1:0] i_range_low,
    input  logic                          i_low_finite,
    input  logic signed [VALUE_WIDTH-1:0] i_range_high,
    input  logic                          i_high_finite,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic signed [VALUE_WIDTH-1:0] o_range_min,
    output logic signed [VALUE_WIDTH-1:0] o_range_max
);

    t_cfg r_cfg;

    logic                          r_in_vld;
    logic signed [TIME_WIDTH-1:0]  r_ts;
    logic signed [VALUE_WIDTH-1:0] r_val, r_low, r_high;
    logic                          r_val_fin, r_low_fin, r_high_fin, r_last;

    logic                          r_out_vld;
    logic [1:0]                    r_status;
    logic signed [VALUE_WIDTH-1:0] r_min, r_max;

    t_class                        w_class;
    logic signed [VALUE_WIDTH-1:0] w_lo, w_hi, w_res_min, w_res_max;
    logic [1:0]                    w_res_status;
    logic                          w_out_free, w_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_min       <= '0;
            r_cfg.win_max       <= '0;
            r_cfg.policy        <= POL_SKIP;
            r_cfg.hold_fwd      <= 1'b0;
            r_cfg.value_present <= 1'b1;
            r_cfg.range_present <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIN_MIN:       r_cfg.win_min       <= i_cfg_data;
                CFG_WIN_MAX:       r_cfg.win_max       <= i_cfg_data;
                CFG_POLICY:        r_cfg.policy        <= i_cfg_data[1:0];
                CFG_HOLD_FWD:      r_cfg.hold_fwd      <= i_cfg_data[0];
                CFG_VALUE_PRESENT: r_cfg.value_present <= i_cfg_data[0];
                CFG_RANGE_PRESENT: r_cfg.range_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_vld || i_ready;
    assign w_step     = r_in_vld && (!r_last || w_out_free);
    assign o_ready    = !r_in_vld || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ts       <= i_timestamp;
            r_val      <= i_sample_value;
            r_val_fin  <= i_value_finite;
            r_low      <= i_range_low;
            r_low_fin  <= i_low_finite;
            r_high     <= i_range_high;
            r_high_fin <= i_high_finite;
            r_last     <= i_last;
        end
    end

    wvrt_classify #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_classify (
        .i_cfg         (r_cfg),
        .i_timestamp   (r_ts),
        .i_sample_value(r_val),
        .i_value_finite(r_val_fin),
        .i_range_low   (r_low),
        .i_low_finite  (r_low_fin),
        .i_range_high  (r_high),
        .i_high_finite (r_high_fin),
        .o_class       (w_class),
        .o_lo          (w_lo),
        .o_hi          (w_hi)
    );

    wvrt_scan #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_step     (w_step),
        .i_last     (r_last),
        .i_class    (w_class),
        .i_timestamp(r_ts),
        .i_lo       (w_lo),
        .i_hi       (w_hi),
        .o_status   (w_res_status),
        .o_range_min(w_res_min),
        .o_range_max(w_res_max)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_step && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_step && r_last) begin
            r_status <= w_res_status;
            r_min    <= w_res_min;
            r_max    <= w_res_max;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_status    = r_status;
    assign o_range_min = r_min;
    assign o_range_max = r_max;

endmodule
`default_nettype wire

// ===== design/wvrt_checker.sv =====
`default_nettype none
module wvrt_checker
    import wvrt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic [1:0]                    o_status,
    input wire logic signed [VALUE_WIDTH-1:0] o_range_min,
    input wire logic signed [VALUE_WIDTH-1:0] o_range_max
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) &&
        $stable(o_range_min) && $stable(o_range_max))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_READY) || (o_status == ST_EMPTY) ||
        (o_status == ST_FAILED))
        else $error("undefined status code");

    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_READY) |-> (o_range_min == '0) && (o_range_max == '0))
        else $error("range not zero on empty or failed transaction");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_READY) |-> o_range_min <= o_range_max)
        else $error("range min above max");

endmodule

bind windowed_value_range_tracker wvrt_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_wvrt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_status   (o_status),
    .o_range_min(o_range_min),
    .o_range_max(o_range_max)
);
`default_nettype wire
